/* rtl/vrre_pkg.sv */
// Package for the voxel refinement rule evaluator: rule codes, item kinds, helpers.
package vrre_pkg;

  typedef enum logic [2:0] {
    RULE_WEIGHTED = 3'd0,
    RULE_CLASS    = 3'd1,
    RULE_PAT9     = 3'd2,
    RULE_PATCORN  = 3'd3,
    RULE_SEVEN    = 3'd4,
    RULE_HEIGHT   = 3'd5,
    RULE_NONE6    = 3'd6,
    RULE_NONE7    = 3'd7
  } rule_e;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic CFG_RULE_SELECT = 1'b0;
  localparam logic CFG_UP_AXIS_Y   = 1'b1;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned NUM_WORDS = 16;

  // Decision of stage 2: forced answer or genome lookup.
  typedef struct packed {
    logic       force_en;
    logic       force_val;
    logic [10:0] idx;
    logic       negate;
  } decide_t;

  function automatic logic nbit(input logic [26:0] n, input int a, input int b, input int c);
    nbit = n[(a + 1) + 3 * (b + 1) + 9 * (c + 1)];
  endfunction

  function automatic logic [8:0] perm_pat(input logic [2:0] s, input logic [2:0] t,
                                          input logic [2:0] v, input int p);
    logic [8:0] r;
    int q0, q1, q2;
    q0 = (p == 0 || p == 3) ? 0 : (p == 1 || p == 5) ? 1 : 2;
    q1 = (p == 0 || p == 4) ? 1 : (p == 1 || p == 3) ? 2 : 0;
    q2 = (p == 0 || p == 5) ? 2 : (p == 1) ? 0 : (p == 2 || p == 4) ? 1 : 1;
    if (p == 3) q2 = 1;
    if (p == 4) q2 = 0;
    r = {v[q2], v[q1], v[q0], t[q2], t[q1], t[q0], s[q2], s[q1], s[q0]};
    perm_pat = r;
  endfunction

endpackage

/* rtl/voxel_refinement_rule_eval_unit.sv */
// Top level of the voxel refinement rule evaluator.
// Three-stage pipeline, one item per cycle; an accepted item passes the stage-1, stage-2 and
// output registers. Stage 1 forms counts, six permuted patterns and the rule-specific index;
// stage 2 takes the minimum pattern and resolves the thresholds into a forced value or a
// genome index; stage 3 reads the genome bit (16 x 64 flop words, one read and one load
// write per cycle) into the output register. A load item writes its genome word as it leaves
// stage 1, so evaluations ahead of it read the old word and those behind it the new one. The
// whole pipe advances unless the output holds a result that is stalled; loads produce no
// result. Config is to be written idle; the block itself does not enforce this.
module voxel_refinement_rule_eval_unit #(
  parameter int unsigned GENOME_BITS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [3:0]  word_index_i,
  input  logic [63:0] word_value_i,
  input  logic [26:0] neighbours_i,
  input  logic        y_odd_i,
  input  logic        z_odd_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        filled_o
);

  localparam int unsigned GWORDS = GENOME_BITS / vrre_pkg::WORD_BITS;

  logic [2:0] rule_q;
  logic       upy_q;
  logic [63:0] genome_q [vrre_pkg::NUM_WORDS];

  logic adv;
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  logic acc;
  assign acc = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= vrre_pkg::RULE_WEIGHTED;
      upy_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vrre_pkg::CFG_RULE_SELECT: rule_q <= cfg_data_i;
        vrre_pkg::CFG_UP_AXIS_Y:   upy_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1
  logic [26:0] n;
  assign n = neighbours_i;
  logic ctr, fourth;
  logic [2:0] s, t, v;
  logic [1:0] second, third, seventh, sec5, sev5;
  logic [3:0] cnt_d;
  logic [6:0] p1, p2;
  logic [7:0] wsum;
  logic [4:0] base8;
  logic [8:0] pats_d [6];
  logic [8:0] fidx_d;
  logic up_d;

  always_comb begin
    ctr = vrre_pkg::nbit(n, 0, 0, 0);
    s = {vrre_pkg::nbit(n, 0, 0, 1), vrre_pkg::nbit(n, 0, 1, 0), vrre_pkg::nbit(n, 1, 0, 0)};
    t = {vrre_pkg::nbit(n, 1, 1, 0), vrre_pkg::nbit(n, 1, 0, 1), vrre_pkg::nbit(n, 0, 1, 1)};
    v = {vrre_pkg::nbit(n, 0, 0, -1), vrre_pkg::nbit(n, 0, -1, 0), vrre_pkg::nbit(n, -1, 0, 0)};
    fourth = vrre_pkg::nbit(n, 1, 1, 1);
    second = 2'(s[0]) + 2'(s[1]) + 2'(s[2]);
    third = 2'(t[0]) + 2'(t[1]) + 2'(t[2]);
    seventh = 2'(v[0]) + 2'(v[1]) + 2'(v[2]);
    sec5 = upy_q ? 2'(s[0]) + 2'(s[2]) : 2'(s[0]) + 2'(s[1]);
    sev5 = upy_q ? 2'(v[0]) + 2'(v[2]) : 2'(v[0]) + 2'(v[1]);
    for (int p = 0; p < 6; p++) pats_d[p] = vrre_pkg::perm_pat(s, t, v, p);
    base8 = 5'(ctr) + 5'(s[0]) + 5'(s[1]) + 5'(s[2]) + 5'(t[0]) + 5'(t[1]) + 5'(t[2])
          + 5'(fourth);
    wsum = {base8[4:0], 3'b000};
    wsum = wsum + (ctr ? 8'd24 : 8'd0);
    for (int kk = 0; kk < 2; kk++) begin
      for (int jj = 0; jj < 2; jj++) begin
        wsum = wsum + 8'(4 * vrre_pkg::nbit(n, -1, jj, kk)) + 8'(4 * vrre_pkg::nbit(n, jj, -1, kk))
             + 8'(4 * vrre_pkg::nbit(n, jj, kk, -1));
      end
      wsum = wsum + 8'(2 * vrre_pkg::nbit(n, kk, -1, -1)) + 8'(2 * vrre_pkg::nbit(n, -1, kk, -1))
           + 8'(2 * vrre_pkg::nbit(n, -1, -1, kk));
    end
    p1 = {v[2], v[1], v[0], s[2], s[1], s[0], ctr};
    p2 = upy_q ? {v[0], v[1], v[2], s[0], s[1], s[2], ctr}
               : {v[2], v[0], v[1], s[2], s[0], s[1], ctr};
    cnt_d = 4'd0;
    fidx_d = 9'd0;
    up_d = upy_q ? ~y_odd_i : z_odd_i;
    case (rule_q)
      vrre_pkg::RULE_WEIGHTED: begin
        cnt_d = base8[3:0];
        fidx_d = 9'(wsum);
      end
      vrre_pkg::RULE_CLASS: begin
        cnt_d = 4'(ctr) + 4'(second) + 4'(third) + 4'(fourth);
        fidx_d = 9'({ctr, second, 3'b000}) + 9'({third, 2'b00}) + 9'(fourth);
      end
      vrre_pkg::RULE_PAT9: cnt_d = 4'(ctr) + 4'(second) + 4'(third) + 4'(seventh);
      vrre_pkg::RULE_PATCORN:
        cnt_d = 4'(ctr) + 4'(second) + 4'(third) + 4'(fourth) + 4'(seventh);
      vrre_pkg::RULE_SEVEN: begin
        cnt_d = 4'(ctr) + 4'(second);
        fidx_d = 9'((p1 < p2) ? p1 : p2);
      end
      vrre_pkg::RULE_HEIGHT: begin
        cnt_d = 4'(ctr) + 4'(sec5) + 4'(third) + 4'(fourth) + 4'(sev5);
        fidx_d = 9'({sev5, 6'd0}) + 9'({ctr, 5'd0}) + 9'({sec5, 3'd0}) + 9'({third, 2'd0})
               + 9'(fourth);
      end
      default: ;
    endcase
  end

  logic v1_q, ctr1_q, four1_q, up1_q;
  logic [2:0] rule1_q;
  logic [3:0] cnt1_q;
  logic [8:0] fidx1_q;
  logic [8:0] pats1_q [6];
  logic        ld1_q;
  logic [3:0]  ldw1_q;
  logic [63:0] ldv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      ld1_q <= 1'b0;
    end else if (adv) begin
      v1_q  <= acc && kind_i == vrre_pkg::KIND_EVAL;
      ld1_q <= acc && kind_i == vrre_pkg::KIND_LOAD && 32'(word_index_i) < GWORDS;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctr1_q <= ctr; four1_q <= fourth; up1_q <= up_d; rule1_q <= rule_q;
      cnt1_q <= cnt_d; fidx1_q <= fidx_d; pats1_q <= pats_d;
      ldw1_q <= word_index_i; ldv1_q <= word_value_i;
    end
  end

  // load leaves stage 1 in item order with the evaluations around it
  always_ff @(posedge clk_i) begin
    if (adv && ld1_q)
      genome_q[ldw1_q] <= ldv1_q;
  end

  // ---------------- stage 2
  vrre_pkg::decide_t dec_d, dec2_q;
  logic [8:0] mp;
  logic [4:0] wi;
  logic [10:0] ix;
  logic v2_q;

  always_comb begin
    mp = pats1_q[0];
    for (int p = 1; p < 6; p++) if (pats1_q[p] < mp) mp = pats1_q[p];
    wi = 5'((fidx1_q[7:0] + 8'd2) >> 3);
    ix = '0;
    dec_d = '0;
    case (rule1_q)
      vrre_pkg::RULE_WEIGHTED: begin
        if (cnt1_q == 4'd0) dec_d.force_en = 1'b1;
        else if (cnt1_q == 4'd8) begin dec_d.force_en = 1'b1; dec_d.force_val = 1'b1; end
        else if (wi <= 5'd3) dec_d.force_en = 1'b1;
        else if (wi >= 5'd16) begin dec_d.force_en = 1'b1; dec_d.force_val = 1'b1; end
        else if (wi < 5'd10) dec_d.idx = 11'(wi);
        else begin dec_d.idx = 11'(5'd15 - wi); dec_d.negate = 1'b1; end
      end
      vrre_pkg::RULE_CLASS: begin
        if (cnt1_q <= 4'd2) dec_d.force_en = 1'b1;
        else if (cnt1_q >= 4'd6) begin dec_d.force_en = 1'b1; dec_d.force_val = 1'b1; end
        else dec_d.idx = 11'(fidx1_q);
      end
      vrre_pkg::RULE_PAT9: begin
        ix = 11'({mp, ctr1_q});
        if (cnt1_q <= 4'd3) dec_d.force_en = 1'b1;
        else if (cnt1_q >= 4'd7) begin dec_d.force_en = 1'b1; dec_d.force_val = 1'b1; end
        else if (ix <= 11'd511) dec_d.idx = ix;
        else begin dec_d.idx = 11'd1023 - ix; dec_d.negate = 1'b1; end
      end
      vrre_pkg::RULE_PATCORN: begin
        ix = {mp, four1_q, ctr1_q};
        if (cnt1_q <= 4'd3) dec_d.force_en = 1'b1;
        else if (cnt1_q >= 4'd8) begin dec_d.force_en = 1'b1; dec_d.force_val = 1'b1; end
        else if (ix <= 11'd1023) dec_d.idx = ix;
        else begin dec_d.idx = 11'd2047 - ix; dec_d.negate = 1'b1; end
      end
      vrre_pkg::RULE_SEVEN: begin
        if (cnt1_q < 4'd1) dec_d.force_en = 1'b1;
        else if (cnt1_q > 4'd3) begin dec_d.force_en = 1'b1; dec_d.force_val = 1'b1; end
        else if (fidx1_q < 9'd64) dec_d.idx = 11'(fidx1_q);
        else dec_d.idx = 11'(9'd127 - fidx1_q);
      end
      vrre_pkg::RULE_HEIGHT: begin
        if (cnt1_q <= 4'd3) dec_d.force_en = 1'b1;
        else if (cnt1_q >= 4'd6) begin dec_d.force_en = 1'b1; dec_d.force_val = 1'b1; end
        else if (fidx1_q < 9'd160) dec_d.idx = 11'(fidx1_q) + (up1_q ? 11'd160 : 11'd0);
        else begin
          dec_d.idx = 11'(9'd319 - fidx1_q) + (up1_q ? 11'd160 : 11'd0);
          dec_d.negate = 1'b1;
        end
      end
      default: dec_d.force_en = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) dec2_q <= dec_d;
  end

  // ---------------- stage 3
  logic bit3, fill_d, out_v_q, fill_q;
  always_comb begin
    bit3 = 1'b0;
    if (32'(dec2_q.idx) < GENOME_BITS && dec2_q.idx < 11'd1024)
      bit3 = genome_q[dec2_q.idx[9:6]][dec2_q.idx[5:0]];
    fill_d = dec2_q.force_en ? dec2_q.force_val : (bit3 ^ dec2_q.negate);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) fill_q <= fill_d;
  end

  assign out_valid_o = out_v_q;
  assign filled_o = fill_q;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filled_o))
    else $error("result changed while stalled");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without pending result");
  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v2_q |=> out_valid_o)
    else $error("item lost in last stage");
`endif

endmodule
